[design/gbpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_pkg
// shared types and constants of the glyph bitmap to pixel expander
// ----------------------------------------------------------------------------
package gbpe_pkg;

	localparam int GEOM_W       = 7;
	localparam int COLOR_W      = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int BYTE_W       = 8;
	localparam int CNT_W        = 3;
	localparam int QUEUE_DEPTH  = 2;

	localparam int WIDTH_RESET  = 17;
	localparam int HEIGHT_RESET = 24;
	localparam logic [COLOR_W-1:0] FORE_RESET = 16'hFFFF;
	localparam logic [COLOR_W-1:0] BACK_RESET = 16'h0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLYPH_WIDTH  = 2'd0,
		REG_GLYPH_HEIGHT = 2'd1,
		REG_FORE_COLOR   = 2'd2,
		REG_BACK_COLOR   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] font_byte;
	} byte_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] px_rgb;
		logic               last_of_byte;
		logic               end_of_row;
		logic               end_of_glyph;
	} pixel_item_t;

	// classified byte: pixel count minus one plus row and glyph flags
	typedef struct packed {
		logic [BYTE_W-1:0] font_byte;
		logic [CNT_W-1:0]  cnt;
		logic              row_end;
		logic              glyph_end;
	} cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0] fore;
		logic [COLOR_W-1:0] back;
	} color_t;

endpackage

[design/gbpe_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_stream_if
// valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface gbpe_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[design/gbpe_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_front
// configuration registers, row and glyph tracking, byte classification
// ----------------------------------------------------------------------------
module gbpe_front #(
	parameter int MAX_GLYPH_WIDTH  = 64,
	parameter int MAX_GLYPH_HEIGHT = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gbpe_stream_if.sink                     glyph,
	input  logic                            cfg_we,
	input  logic [gbpe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gbpe_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            q_full,
	output logic                            q_push,
	output gbpe_pkg::cmd_t                  q_cmd,
	output gbpe_pkg::color_t                colors
);
	localparam int LW = $clog2(MAX_GLYPH_WIDTH + 1);
	localparam int LH = $clog2(MAX_GLYPH_HEIGHT + 1);
	localparam int RW = $clog2(MAX_GLYPH_HEIGHT);
	localparam int RST_W = (gbpe_pkg::WIDTH_RESET > MAX_GLYPH_WIDTH) ?
		MAX_GLYPH_WIDTH : gbpe_pkg::WIDTH_RESET;

	logic [gbpe_pkg::GEOM_W-1:0]  width_q;
	logic [gbpe_pkg::GEOM_W-1:0]  height_q;
	logic [gbpe_pkg::COLOR_W-1:0] fore_q;
	logic [gbpe_pkg::COLOR_W-1:0] back_q;
	logic [LW-1:0]                left_q;
	logic [RW-1:0]                row_q;

	logic [LW-1:0] w_eff;
	logic [LH-1:0] h_eff;
	logic [LH-1:0] h_last;
	logic [LW-1:0] left_m1;
	logic          left_gt8;
	logic          row_ends;
	logic          glyph_ends;
	logic          restart;
	logic          accept;
	gbpe_pkg::reg_idx_t idx;

	// effective geometry with saturation
	always_comb begin
		if (width_q == '0)
			w_eff = LW'(1);
		else if (width_q > gbpe_pkg::GEOM_W'(MAX_GLYPH_WIDTH))
			w_eff = LW'(MAX_GLYPH_WIDTH);
		else
			w_eff = width_q[LW-1:0];
		if (height_q == '0)
			h_eff = LH'(1);
		else if (height_q > gbpe_pkg::GEOM_W'(MAX_GLYPH_HEIGHT))
			h_eff = LH'(MAX_GLYPH_HEIGHT);
		else
			h_eff = height_q[LH-1:0];
	end

	assign h_last     = h_eff - LH'(1);
	assign left_m1    = left_q - LW'(1);
	assign left_gt8   = left_q > LW'(8);
	assign row_ends   = !left_gt8;
	assign glyph_ends = row_ends && (LH'(row_q) == h_last);

	assign glyph.ready = !q_full;
	assign accept      = glyph.valid && !q_full;
	assign q_push      = accept;

	assign q_cmd.font_byte = glyph.payload.font_byte;
	assign q_cmd.cnt       = left_gt8 ? gbpe_pkg::CNT_W'(7) : left_m1[gbpe_pkg::CNT_W-1:0];
	assign q_cmd.row_end   = row_ends;
	assign q_cmd.glyph_end = glyph_ends;

	assign colors.fore = fore_q;
	assign colors.back = back_q;

	assign idx     = gbpe_pkg::reg_idx_t'(cfg_idx);
	assign restart = cfg_we && (idx == gbpe_pkg::REG_GLYPH_WIDTH ||
		idx == gbpe_pkg::REG_GLYPH_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gbpe_pkg::GEOM_W'(gbpe_pkg::WIDTH_RESET);
			height_q <= gbpe_pkg::GEOM_W'(gbpe_pkg::HEIGHT_RESET);
			fore_q   <= gbpe_pkg::FORE_RESET;
			back_q   <= gbpe_pkg::BACK_RESET;
		end else if (cfg_we) begin
			unique case (idx)
				gbpe_pkg::REG_GLYPH_WIDTH:  width_q  <= cfg_wdata[gbpe_pkg::GEOM_W-1:0];
				gbpe_pkg::REG_GLYPH_HEIGHT: height_q <= cfg_wdata[gbpe_pkg::GEOM_W-1:0];
				gbpe_pkg::REG_FORE_COLOR:   fore_q   <= cfg_wdata;
				gbpe_pkg::REG_BACK_COLOR:   back_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// position tracking, geometry writes restart the glyph
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= LW'(RST_W);
			row_q  <= '0;
		end else if (restart) begin
			if (idx == gbpe_pkg::REG_GLYPH_WIDTH) begin
				if (cfg_wdata[gbpe_pkg::GEOM_W-1:0] == '0)
					left_q <= LW'(1);
				else if (cfg_wdata[gbpe_pkg::GEOM_W-1:0] >
						gbpe_pkg::GEOM_W'(MAX_GLYPH_WIDTH))
					left_q <= LW'(MAX_GLYPH_WIDTH);
				else
					left_q <= cfg_wdata[LW-1:0];
			end else begin
				left_q <= w_eff;
			end
			row_q <= '0;
		end else if (accept) begin
			if (row_ends) begin
				left_q <= w_eff;
				row_q  <= glyph_ends ? '0 : row_q + RW'(1);
			end else begin
				left_q <= left_q - LW'(8);
			end
		end
	end
endmodule

[design/gbpe_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_fifo
// short command queue between the classifier and the pixel serializer
// ----------------------------------------------------------------------------
module gbpe_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gbpe_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           valid,
	output gbpe_pkg::cmd_t head,
	input  logic           pop
);
	localparam int DEPTH = gbpe_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	gbpe_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign valid   = count_q != '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end
endmodule

[design/gbpe_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_back
// pixel serializer, one pixel per cycle to a registered output unless stalled
// ----------------------------------------------------------------------------
module gbpe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  gbpe_pkg::cmd_t   q_head,
	output logic             q_pop,
	input  gbpe_pkg::color_t colors,
	gbpe_stream_if.source    pixel
);
	logic                       busy_q;
	logic [gbpe_pkg::BYTE_W-1:0] bits_q;
	logic [gbpe_pkg::CNT_W-1:0]  cnt_q;
	logic                       row_end_q;
	logic                       glyph_end_q;
	logic                       out_valid_q;
	gbpe_pkg::pixel_item_t      out_q;

	logic out_free;
	logic emit;
	logic last;
	logic load;

	assign out_free = !out_valid_q || pixel.ready;
	assign emit     = busy_q && out_free;
	assign last     = cnt_q == '0;
	assign load     = q_valid && (!busy_q || (emit && last));
	assign q_pop    = load;

	assign pixel.valid   = out_valid_q;
	assign pixel.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				busy_q <= 1'b1;
			else if (emit && last)
				busy_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (pixel.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bits_q      <= q_head.font_byte;
			cnt_q       <= q_head.cnt;
			row_end_q   <= q_head.row_end;
			glyph_end_q <= q_head.glyph_end;
		end else if (emit) begin
			bits_q <= {bits_q[gbpe_pkg::BYTE_W-2:0], 1'b0};
			cnt_q  <= cnt_q - gbpe_pkg::CNT_W'(1);
		end
		if (emit) begin
			out_q.px_rgb       <= bits_q[gbpe_pkg::BYTE_W-1] ? colors.fore : colors.back;
			out_q.last_of_byte <= last;
			out_q.end_of_row   <= last && row_end_q;
			out_q.end_of_glyph <= last && glyph_end_q;
		end
	end
endmodule

[design/glyph_bitmap_to_pixel_expander.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_to_pixel_expander
// expands 1bpp glyph bitmap bytes into RGB565 pixels with position flags
// ----------------------------------------------------------------------------
//  channel  dir  payload                                              per transfer
//  glyph    in   font_byte                                            one byte
//  pixel    out  px_rgb last_of_byte end_of_row end_of_glyph          one pixel
//  cfg      in   cfg_we cfg_idx cfg_wdata                             one register
//
//  a byte gives 1 to 8 pixels, one per cycle from the output register while
//  pixel.ready does not hold it
//  bytes enter one per cycle while the two-entry queue has room
//  asynchronous reset clears control state; no clearing pass
//  pixel.ready low holds the output register, the queue fills, glyph.ready drops
// ----------------------------------------------------------------------------
module glyph_bitmap_to_pixel_expander #(
	parameter int MAX_GLYPH_WIDTH  = 64,
	parameter int MAX_GLYPH_HEIGHT = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gbpe_stream_if.sink                     glyph,
	gbpe_stream_if.source                   pixel,
	input  logic                            cfg_we,
	input  logic [gbpe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gbpe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	logic             q_push;
	logic             q_full;
	logic             q_valid;
	logic             q_pop;
	gbpe_pkg::cmd_t   push_cmd;
	gbpe_pkg::cmd_t   head_cmd;
	gbpe_pkg::color_t colors;

	gbpe_front #(
		.MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
		.MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.glyph     (glyph),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd),
		.colors    (colors)
	);

	gbpe_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.valid    (q_valid),
		.head     (head_cmd),
		.pop      (q_pop)
	);

	gbpe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (head_cmd),
		.q_pop   (q_pop),
		.colors  (colors),
		.pixel   (pixel)
	);
endmodule

[design/gbpe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_checker
// port level checks of the pixel output, bound to the top level
// ----------------------------------------------------------------------------
module gbpe_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input gbpe_pkg::pixel_item_t out_item
);
	// a stalled pixel stays and holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("pixel changed while stalled");

	a_glyph_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.end_of_glyph |-> out_item.end_of_row)
		else $error("end of glyph without end of row");

	a_row_in_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.end_of_row |-> out_item.last_of_byte)
		else $error("end of row without last of byte");

	// a row end is the last pixel of its byte, so the next transfer starts a new byte
	a_byte_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last_of_byte |=>
			!(out_valid && out_item.end_of_glyph && $past(out_item.end_of_glyph)))
		else $error("glyph end repeated inside a byte");
endmodule

bind glyph_bitmap_to_pixel_expander gbpe_checker u_gbpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (pixel.valid),
	.out_ready (pixel.ready),
	.out_item  (pixel.payload)
);

[tb/tb_glyph_bitmap_to_pixel_expander.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_bitmap_to_pixel_expander
// self-checking bench for the glyph bitmap to pixel expander: a directed
// table of bytes and register writes, then random glyph geometry, colors and
// bitmap bytes under three idling profiles and one long output hold-off;
// every pixel transfer is checked field by field against literal table pixels
// or a local expansion model kept in step with the register writes
// ----------------------------------------------------------------------------
module tb_glyph_bitmap_to_pixel_expander;

	localparam int MAX_W       = 64;
	localparam int MAX_H       = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 58;

	localparam logic ROW_CFG  = 1'b1;
	localparam logic ROW_BYTE = 1'b0;
	localparam logic LIT      = 1'b1;
	localparam logic PRED     = 1'b0;

	localparam gbpe_pkg::reg_idx_t R_WID = gbpe_pkg::REG_GLYPH_WIDTH;
	localparam gbpe_pkg::reg_idx_t R_HGT = gbpe_pkg::REG_GLYPH_HEIGHT;
	localparam gbpe_pkg::reg_idx_t R_FG  = gbpe_pkg::REG_FORE_COLOR;
	localparam gbpe_pkg::reg_idx_t R_BG  = gbpe_pkg::REG_BACK_COLOR;

	typedef struct packed {
		logic                         kind;
		gbpe_pkg::reg_idx_t           idx;
		logic [gbpe_pkg::COLOR_W-1:0] data;
		logic [gbpe_pkg::BYTE_W-1:0]  fbyte;
		logic                         lit;
		logic [3:0]                   lit_n;
		logic [gbpe_pkg::COLOR_W-1:0] lit_color;
		logic                         lit_eor;
		logic                         lit_eog;
	} dir_row_t;

	localparam int DIR_ROWS = 38;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{ROW_BYTE, R_WID, 16'h0000, 8'hFF, LIT,  4'd8, 16'hFFFF, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h00, LIT,  4'd8, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'hFF, LIT,  4'd1, 16'hFFFF, 1'b1, 1'b0},
		'{ROW_CFG,  R_WID, 16'h0001, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_HGT, 16'h0001, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h80, LIT,  4'd1, 16'hFFFF, 1'b1, 1'b1},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h7F, LIT,  4'd1, 16'h0000, 1'b1, 1'b1},
		'{ROW_CFG,  R_FG,  16'h1234, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_BG,  16'hABCD, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_WID, 16'h0000, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_HGT, 16'h0000, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'hA5, LIT,  4'd1, 16'h1234, 1'b1, 1'b1},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h5A, LIT,  4'd1, 16'hABCD, 1'b1, 1'b1},
		'{ROW_CFG,  R_WID, 16'hFFFF, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_HGT, 16'h0080, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h01, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h02, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h04, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h08, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h10, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h20, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h40, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h80, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_FG,  16'h0000, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_BG,  16'hFFFF, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_WID, 16'h0008, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_HGT, 16'h0002, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'hFF, LIT,  4'd8, 16'h0000, 1'b1, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h00, LIT,  4'd8, 16'hFFFF, 1'b1, 1'b1},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h3C, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_WID, 16'h000C, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'hC3, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_WID, 16'h000C, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'h96, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'hF0, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_HGT, 16'h0040, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_CFG,  R_WID, 16'h0040, 8'h00, PRED, 4'd0, 16'h0000, 1'b0, 1'b0},
		'{ROW_BYTE, R_WID, 16'h0000, 8'hE7, PRED, 4'd0, 16'h0000, 1'b0, 1'b0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [gbpe_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [gbpe_pkg::CFG_DATA_W-1:0] cfg_wdata;

	gbpe_stream_if #(.payload_t(gbpe_pkg::byte_item_t))  glyph_ch ();
	gbpe_stream_if #(.payload_t(gbpe_pkg::pixel_item_t)) pixel_ch ();

	glyph_bitmap_to_pixel_expander dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.glyph     (glyph_ch),
		.pixel     (pixel_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// expansion model state
	logic [gbpe_pkg::GEOM_W-1:0]  geo_width;
	logic [gbpe_pkg::GEOM_W-1:0]  geo_height;
	logic [gbpe_pkg::COLOR_W-1:0] fore_col;
	logic [gbpe_pkg::COLOR_W-1:0] back_col;
	logic [gbpe_pkg::GEOM_W-1:0]  px_left;
	logic [gbpe_pkg::GEOM_W-1:0]  row_idx;

	gbpe_pkg::pixel_item_t pending_pixels [$];
	int                    mismatch_count;
	int                    pixel_count;
	int                    send_idle_pct;
	int                    recv_idle_pct;
	logic                  hold_req;
	int                    hold_left;
	logic                  hold_taken;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int eff_dim(logic [gbpe_pkg::GEOM_W-1:0] v, int max_dim);
		if (v == 0)
			return 1;
		if (v > max_dim)
			return max_dim;
		return int'(v);
	endfunction

	function automatic void restart_glyph();
		px_left = gbpe_pkg::GEOM_W'(eff_dim(geo_width, MAX_W));
		row_idx = '0;
	endfunction

	function automatic void apply_reg_write(gbpe_pkg::reg_idx_t idx,
		logic [gbpe_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			gbpe_pkg::REG_GLYPH_WIDTH: begin
				geo_width = data[gbpe_pkg::GEOM_W-1:0];
				restart_glyph();
			end
			gbpe_pkg::REG_GLYPH_HEIGHT: begin
				geo_height = data[gbpe_pkg::GEOM_W-1:0];
				restart_glyph();
			end
			gbpe_pkg::REG_FORE_COLOR: begin
				fore_col = data;
			end
			gbpe_pkg::REG_BACK_COLOR: begin
				back_col = data;
			end
			default: begin
			end
		endcase
	endfunction

	// advances the glyph position by one byte; keep pushes the predicted pixels
	function automatic void expand_byte(logic [gbpe_pkg::BYTE_W-1:0] b, logic keep);
		int                    w;
		int                    h;
		int                    left;
		int                    row;
		int                    n;
		logic                  row_ends;
		logic                  glyph_ends;
		gbpe_pkg::pixel_item_t px;
		w    = eff_dim(geo_width, MAX_W);
		h    = eff_dim(geo_height, MAX_H);
		left = int'(px_left);
		row  = int'(row_idx);
		if (left == 0 || left > w)
			left = w;
		if (row >= h)
			row = 0;
		n          = (left > 8) ? 8 : left;
		row_ends   = (n == left);
		glyph_ends = row_ends && (row == h - 1);
		for (int k = 0; k < n; k++) begin
			px.px_rgb       = b[7-k] ? fore_col : back_col;
			px.last_of_byte = (k == n - 1);
			px.end_of_row   = (k == n - 1) && row_ends;
			px.end_of_glyph = (k == n - 1) && glyph_ends;
			if (keep)
				pending_pixels.push_back(px);
		end
		left -= n;
		if (left == 0) begin
			left = w;
			row++;
			if (row >= h)
				row = 0;
		end
		px_left = gbpe_pkg::GEOM_W'(left);
		row_idx = gbpe_pkg::GEOM_W'(row);
	endfunction

	function automatic void push_literal(dir_row_t r);
		gbpe_pkg::pixel_item_t px;
		for (int k = 0; k < r.lit_n; k++) begin
			px.px_rgb       = r.lit_color;
			px.last_of_byte = (k == r.lit_n - 1);
			px.end_of_row   = (k == r.lit_n - 1) && r.lit_eor;
			px.end_of_glyph = (k == r.lit_n - 1) && r.lit_eog;
			pending_pixels.push_back(px);
		end
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch at pixel %0d: %s got %h want %h", pixel_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		glyph_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(gbpe_pkg::reg_idx_t idx, logic [gbpe_pkg::CFG_DATA_W-1:0] data);
		wait_for_drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		apply_reg_write(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_byte(logic [gbpe_pkg::BYTE_W-1:0] b, logic keep);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			glyph_ch.valid <= 1'b0;
			@(negedge clk);
		end
		glyph_ch.valid   <= 1'b1;
		glyph_ch.payload <= b;
		@(posedge clk);
		while (!glyph_ch.ready)
			@(posedge clk);
		expand_byte(b, keep);
	endtask

	// receiver side
	initial pixel_ch.ready = 1'b0;

	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_left  = HOLD_CYCLES;
			hold_taken = 1'b1;
		end
		if (hold_left > 0) begin
			pixel_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			pixel_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		gbpe_pkg::pixel_item_t got;
		gbpe_pkg::pixel_item_t want;
		if (arst_n && pixel_ch.valid && pixel_ch.ready) begin
			got = pixel_ch.payload;
			if (pending_pixels.size() == 0) begin
				flag_mismatch("unexpected pixel, color", int'(got.px_rgb), 0);
			end else begin
				want = pending_pixels.pop_front();
				if (got.px_rgb !== want.px_rgb)
					flag_mismatch("px_rgb", int'(got.px_rgb), int'(want.px_rgb));
				if (got.last_of_byte !== want.last_of_byte)
					flag_mismatch("last_of_byte", int'(got.last_of_byte),
						int'(want.last_of_byte));
				if (got.end_of_row !== want.end_of_row)
					flag_mismatch("end_of_row", int'(got.end_of_row),
						int'(want.end_of_row));
				if (got.end_of_glyph !== want.end_of_glyph)
					flag_mismatch("end_of_glyph", int'(got.end_of_glyph),
						int'(want.end_of_glyph));
			end
			pixel_count++;
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin
		dir_row_t                    r;
		int                          seg_len;
		int                          phase_items;
		int                          pick;
		logic [gbpe_pkg::GEOM_W-1:0] g;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = '0;
		cfg_wdata        = '0;
		glyph_ch.valid   = 1'b0;
		glyph_ch.payload = '0;
		mismatch_count   = 0;
		pixel_count      = 0;
		hold_req         = 1'b0;
		hold_left        = 0;
		hold_taken       = 1'b0;
		send_idle_pct    = 26;
		recv_idle_pct    = 73;
		geo_width        = gbpe_pkg::GEOM_W'(gbpe_pkg::WIDTH_RESET);
		geo_height       = gbpe_pkg::GEOM_W'(gbpe_pkg::HEIGHT_RESET);
		fore_col         = gbpe_pkg::FORE_RESET;
		back_col         = gbpe_pkg::BACK_RESET;
		restart_glyph();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			r = DIR_TABLE[i];
			if (r.kind == ROW_CFG) begin
				write_reg(r.idx, r.data);
			end else if (r.lit == LIT) begin
				send_byte(r.fbyte, 1'b0);
				push_literal(r);
			end else begin
				send_byte(r.fbyte, 1'b1);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(1)) begin
					pick = $urandom_range(9);
					if (pick == 0)
						g = '0;
					else if (pick == 1)
						g = gbpe_pkg::GEOM_W'($urandom_range(127, 64));
					else
						g = gbpe_pkg::GEOM_W'($urandom_range(20, 1));
					write_reg(gbpe_pkg::REG_GLYPH_WIDTH,
						gbpe_pkg::CFG_DATA_W'(($urandom() & 32'hFF80) | g));
				end
				if ($urandom_range(1)) begin
					pick = $urandom_range(9);
					if (pick == 0)
						g = '0;
					else if (pick == 1)
						g = gbpe_pkg::GEOM_W'($urandom_range(127, 64));
					else if (pick <= 3)
						g = gbpe_pkg::GEOM_W'($urandom_range(64, 5));
					else
						g = gbpe_pkg::GEOM_W'($urandom_range(4, 1));
					write_reg(gbpe_pkg::REG_GLYPH_HEIGHT,
						gbpe_pkg::CFG_DATA_W'(($urandom() & 32'hFF80) | g));
				end
				if ($urandom_range(1))
					write_reg(gbpe_pkg::REG_FORE_COLOR,
						gbpe_pkg::CFG_DATA_W'($urandom()));
				if ($urandom_range(1))
					write_reg(gbpe_pkg::REG_BACK_COLOR,
						gbpe_pkg::CFG_DATA_W'($urandom()));
				seg_len = $urandom_range(24, 6);
				for (int j = 0; j < seg_len; j++) begin
					// long output hold-off while the sender keeps offering bytes
					if (phase == 2)
						hold_req = 1'b1;
					send_byte(gbpe_pkg::BYTE_W'($urandom_range(255)), 1'b1);
					phase_items++;
				end
			end
		end

		wait_for_drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && pending_pixels.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
design/gbpe_pkg.sv
design/gbpe_stream_if.sv
design/gbpe_front.sv
design/gbpe_fifo.sv
design/gbpe_back.sv
design/glyph_bitmap_to_pixel_expander.sv
design/gbpe_checker.sv
tb/tb_glyph_bitmap_to_pixel_expander.sv
